// ----- hdl/ialu_pkg.sv -----
// Shared types and codes of the integer ALU with compare.
package ialu_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned Stages = WordW;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_XOR = 4'd4,
        CMD_NEG = 4'd5,
        CMD_REM = 4'd6,
        CMD_GT  = 4'd7,
        CMD_GE  = 4'd8,
        CMD_LT  = 4'd9,
        CMD_LE  = 4'd10,
        CMD_EQ  = 4'd11,
        CMD_NE  = 4'd12
    } t_cmd;

    typedef struct packed {
        logic [3:0]       cmd;
        logic             is_unsigned;
        logic             to_hi_lo;
        logic [WordW-1:0] operand_a;
        logic [WordW-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic [WordW-1:0] result_word;
        logic [WordW-1:0] high_word;
        logic             pair_written;
        logic             divide_by_zero;
    } t_out_word;

    // One slot of the pipeline as it passes from cell to cell.
    typedef struct packed {
        logic               valid;
        logic [3:0]         cmd;
        logic               pair;
        logic               neg_a;
        logic               neg_b;
        logic               dz;
        logic [WordW-1:0]   operand_a;
        logic [WordW-1:0]   simple;
        logic [2*WordW-1:0] prod;
        logic [WordW-1:0]   part_rem;
        logic [WordW-1:0]   quo;
        logic [WordW-1:0]   dvs;
    } t_lane;

endpackage

// ----- hdl/ialu_front.sv -----
// Entry stage: simple operations, the product and the divider set-up.
module ialu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  ialu_pkg::t_in_word i_word,
    output ialu_pkg::t_lane   o_lane
);

    ialu_pkg::t_lane r_lane;
    ialu_pkg::t_lane n_lane;

    logic                          ext_a;
    logic                          ext_b;
    logic signed [2*ialu_pkg::WordW+1:0] prod_full;
    logic signed [ialu_pkg::WordW-1:0]   sa;
    logic signed [ialu_pkg::WordW-1:0]   sb;

    always_comb begin
        sa        = $signed(i_word.operand_a);
        sb        = $signed(i_word.operand_b);
        ext_a     = ~i_word.is_unsigned & i_word.operand_a[ialu_pkg::WordW-1];
        ext_b     = ~i_word.is_unsigned & i_word.operand_b[ialu_pkg::WordW-1];
        prod_full = $signed({ext_a, i_word.operand_a}) * $signed({ext_b, i_word.operand_b});

        n_lane           = '0;
        n_lane.valid     = i_valid;
        n_lane.cmd       = i_word.cmd;
        n_lane.pair      = i_word.to_hi_lo;
        n_lane.neg_a     = ext_a;
        n_lane.neg_b     = ext_b;
        n_lane.dz        = (i_word.operand_b == '0);
        n_lane.operand_a = i_word.operand_a;
        n_lane.prod      = prod_full[2*ialu_pkg::WordW-1:0];
        n_lane.part_rem  = '0;
        n_lane.quo       = ext_a ? (ialu_pkg::WordW'(0) - i_word.operand_a)
                                 : i_word.operand_a;
        n_lane.dvs       = ext_b ? (ialu_pkg::WordW'(0) - i_word.operand_b)
                                 : i_word.operand_b;

        case (i_word.cmd)
            ialu_pkg::CMD_ADD: n_lane.simple = i_word.operand_a + i_word.operand_b;
            ialu_pkg::CMD_SUB: n_lane.simple = i_word.operand_a - i_word.operand_b;
            ialu_pkg::CMD_XOR: n_lane.simple = i_word.operand_a ^ i_word.operand_b;
            ialu_pkg::CMD_NEG: n_lane.simple = i_word.is_unsigned ? ~i_word.operand_a
                                   : (ialu_pkg::WordW'(0) - i_word.operand_a);
            ialu_pkg::CMD_GT:  n_lane.simple = ialu_pkg::WordW'(sa > sb);
            ialu_pkg::CMD_GE:  n_lane.simple = ialu_pkg::WordW'(sa >= sb);
            ialu_pkg::CMD_LT:  n_lane.simple = ialu_pkg::WordW'(sa < sb);
            ialu_pkg::CMD_LE:  n_lane.simple = ialu_pkg::WordW'(sa <= sb);
            ialu_pkg::CMD_EQ:  n_lane.simple = ialu_pkg::WordW'(i_word.operand_a ==
                                                               i_word.operand_b);
            ialu_pkg::CMD_NE:  n_lane.simple = ialu_pkg::WordW'(i_word.operand_a !=
                                                               i_word.operand_b);
            default:           n_lane.simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- hdl/ialu_div_cell.sv -----
// One restoring division step; all other lane fields pass through.
module ialu_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ialu_pkg::t_lane i_lane,
    output ialu_pkg::t_lane o_lane
);

    ialu_pkg::t_lane             r_lane;
    ialu_pkg::t_lane             n_lane;
    logic [ialu_pkg::WordW:0]    shifted;
    logic [ialu_pkg::WordW:0]    diff;

    always_comb begin
        n_lane  = i_lane;
        shifted = {i_lane.part_rem, i_lane.quo[ialu_pkg::WordW-1]};
        diff    = shifted - {1'b0, i_lane.dvs};
        if (!diff[ialu_pkg::WordW]) begin
            n_lane.part_rem = diff[ialu_pkg::WordW-1:0];
            n_lane.quo      = {i_lane.quo[ialu_pkg::WordW-2:0], 1'b1};
        end else begin
            n_lane.part_rem = shifted[ialu_pkg::WordW-1:0];
            n_lane.quo      = {i_lane.quo[ialu_pkg::WordW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- hdl/ialu_back.sv -----
// Exit stage: sign fix-up, result selection and the output register.
module ialu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ialu_pkg::t_lane     i_lane,
    output logic                o_valid,
    output ialu_pkg::t_out_word o_word
);

    ialu_pkg::t_out_word       r_word;
    ialu_pkg::t_out_word       n_word;
    logic                      r_valid;
    logic [ialu_pkg::WordW-1:0] quo;
    logic [ialu_pkg::WordW-1:0] rem;

    always_comb begin
        if (i_lane.dz) begin
            quo = '1;
            rem = i_lane.operand_a;
        end else begin
            quo = (i_lane.neg_a != i_lane.neg_b) ? (ialu_pkg::WordW'(0) - i_lane.quo)
                                                 : i_lane.quo;
            rem = i_lane.neg_a ? (ialu_pkg::WordW'(0) - i_lane.part_rem)
                               : i_lane.part_rem;
        end

        n_word = '0;
        case (i_lane.cmd)
            ialu_pkg::CMD_MUL: begin
                n_word.result_word  = i_lane.prod[ialu_pkg::WordW-1:0];
                n_word.high_word    = i_lane.pair ?
                                      i_lane.prod[2*ialu_pkg::WordW-1:ialu_pkg::WordW] : '0;
                n_word.pair_written = i_lane.pair;
            end
            ialu_pkg::CMD_DIV: begin
                n_word.result_word    = quo;
                n_word.high_word      = i_lane.pair ? rem : '0;
                n_word.pair_written   = i_lane.pair;
                n_word.divide_by_zero = i_lane.dz;
            end
            ialu_pkg::CMD_REM: begin
                n_word.result_word    = rem;
                n_word.divide_by_zero = i_lane.dz;
            end
            default: begin
                n_word.result_word = i_lane.simple;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- hdl/integer_alu_with_compare.sv -----
// Top level of the pipelined integer ALU with compare.
//
// Input channel: i_in_valid / o_in_ready carry one word (command, unsigned
// flag, hi/lo flag and two 32-bit operands). Output channel: o_out_valid /
// i_out_ready carry one result word per input word, in order.
// Every command travels the same pipeline: an entry stage that works out
// the simple operations and the full product, a row of 32 division cells
// that each settle one quotient bit, and an output register. Every command
// therefore takes equally long, and one word may enter in every cycle
// while the output register is empty or being read, so the sustained rate
// is one word per clock when the receiver does not stall.
// When the receiver stalls, the whole row holds as one; the pipeline keeps
// taking words until the output register is full and unread, at which point
// o_in_ready drops in the same cycle. The row of division cells sets the
// latency; the 33 by 33 bit multiplier in the entry stage and the 33-bit
// subtract in each cell set the clock period.
// Reset (synchronous, active low) empties every stage and drops any word in
// flight; no word is invented, and the block is ready in the cycle after reset.
module integer_alu_with_compare (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ialu_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ialu_pkg::t_out_word o_out_word
);

    // The pipeline advances whenever the output register is empty or is
    // being read in this cycle.
    logic            advance;
    ialu_pkg::t_lane lane [0:ialu_pkg::Stages];

    assign advance    = ~o_out_valid | i_out_ready;
    assign o_in_ready = advance;

    ialu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_lane  (lane[0])
    );

    // One cell per quotient bit, most significant first.
    for (genvar g = 0; g < ialu_pkg::Stages; g++) begin : g_cell
        ialu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_lane  (lane[g]),
            .o_lane  (lane[g+1])
        );
    end

    ialu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_lane  (lane[ialu_pkg::Stages]),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the pipelined integer ALU with compare.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned Latency    = 33;
    localparam int unsigned RandomWords = 1030;

    // Idling modes of the run: sender lazy, receiver lazy, then neither.
    typedef enum int {
        MODE_SEND_LAZY,
        MODE_RECV_LAZY,
        MODE_NO_IDLE
    } t_idle_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    ialu_pkg::t_in_word  i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    ialu_pkg::t_out_word o_out_word;

    integer_alu_with_compare dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    // Results still owed by the block, oldest first.
    ialu_pkg::t_out_word pending_results[$];
    t_idle_mode idle_mode = MODE_SEND_LAZY;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned hold_off = 0;

    // One row of the directed table. Where has_golden is set the result is
    // typed in by hand and the predictor is checked against it as well.
    typedef struct {
        ialu_pkg::t_in_word  stim;
        bit                  has_golden;
        ialu_pkg::t_out_word golden;
    } t_table_row;

    t_table_row directed_rows[$];

    // Quotient and remainder, truncating toward zero, with the zero divisor
    // and overflow behaviour of the block.
    function automatic void divide_words(input logic [31:0] a, input logic [31:0] b,
                                         input bit signed_op,
                                         output logic [31:0] quo,
                                         output logic [31:0] rem, output bit dz);
        bit          na;
        bit          nb;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        logic [31:0] r;
        if (b == 32'd0) begin
            quo = '1;
            rem = a;
            dz  = 1'b1;
            return;
        end
        na = signed_op && a[31];
        nb = signed_op && b[31];
        ua = na ? -a : a;
        ub = nb ? -b : b;
        q = ua / ub;
        r = ua % ub;
        quo = (na != nb) ? -q : q;
        rem = na ? -r : r;
        dz  = 1'b0;
    endfunction

    function automatic ialu_pkg::t_out_word compute_alu_result(input ialu_pkg::t_in_word w);
        ialu_pkg::t_out_word o;
        logic [63:0] prod;
        logic [31:0] q;
        logic [31:0] r;
        bit          dz;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        o  = '0;
        sa = w.operand_a;
        sb = w.operand_b;
        case (w.cmd)
            ialu_pkg::CMD_ADD: o.result_word = w.operand_a + w.operand_b;
            ialu_pkg::CMD_SUB: o.result_word = w.operand_a - w.operand_b;
            ialu_pkg::CMD_MUL: begin
                if (w.is_unsigned) begin
                    prod = {32'd0, w.operand_a} * {32'd0, w.operand_b};
                end else begin
                    prod = $signed({{32{sa[31]}}, sa}) * $signed({{32{sb[31]}}, sb});
                end
                o.result_word = prod[31:0];
                if (w.to_hi_lo) begin
                    o.high_word    = prod[63:32];
                    o.pair_written = 1'b1;
                end
            end
            ialu_pkg::CMD_DIV: begin
                divide_words(w.operand_a, w.operand_b, !w.is_unsigned, q, r, dz);
                o.result_word    = q;
                o.divide_by_zero = dz;
                if (w.to_hi_lo) begin
                    o.high_word    = r;
                    o.pair_written = 1'b1;
                end
            end
            ialu_pkg::CMD_XOR: o.result_word = w.operand_a ^ w.operand_b;
            ialu_pkg::CMD_NEG: o.result_word = w.is_unsigned ? ~w.operand_a : -w.operand_a;
            ialu_pkg::CMD_REM: begin
                divide_words(w.operand_a, w.operand_b, !w.is_unsigned, q, r, dz);
                o.result_word    = r;
                o.divide_by_zero = dz;
            end
            ialu_pkg::CMD_GT: o.result_word = {31'd0, sa > sb};
            ialu_pkg::CMD_GE: o.result_word = {31'd0, sa >= sb};
            ialu_pkg::CMD_LT: o.result_word = {31'd0, sa < sb};
            ialu_pkg::CMD_LE: o.result_word = {31'd0, sa <= sb};
            ialu_pkg::CMD_EQ: o.result_word = {31'd0, w.operand_a == w.operand_b};
            ialu_pkg::CMD_NE: o.result_word = {31'd0, w.operand_a != w.operand_b};
            default: o = '0;
        endcase
        return o;
    endfunction

    function automatic ialu_pkg::t_in_word make_word(input logic [3:0] cmd, input bit uns,
                                                     input bit pair, input logic [31:0] a,
                                                     input logic [31:0] b);
        ialu_pkg::t_in_word w;
        w.cmd = cmd;
        w.is_unsigned = uns;
        w.to_hi_lo = pair;
        w.operand_a = a;
        w.operand_b = b;
        return w;
    endfunction

    task automatic add_row(input ialu_pkg::t_in_word w, input bit golden_known,
                           input ialu_pkg::t_out_word golden);
        t_table_row row;
        row.stim = w;
        row.has_golden = golden_known;
        row.golden = golden;
        directed_rows.push_back(row);
    endtask

    function automatic ialu_pkg::t_out_word mk_out(input logic [31:0] res,
                                                   input logic [31:0] hi,
                                                   input bit pair, input bit dz);
        ialu_pkg::t_out_word o;
        o.result_word = res;
        o.high_word = hi;
        o.pair_written = pair;
        o.divide_by_zero = dz;
        return o;
    endfunction

    // Random operands lean on the corners, where carries and signs bite.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 15);
            5: return -$urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // Every accepted word is predicted at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pending_results.push_back(compute_alu_result(i_in_word));
            words_sent <= words_sent + 1;
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        ialu_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word %h", o_out_word);
                end
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (o_out_word !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: res %h/%h hi %h/%h pair %b/%b dz %b/%b",
                                 want.result_word, o_out_word.result_word,
                                 want.high_word, o_out_word.high_word,
                                 want.pair_written, o_out_word.pair_written,
                                 want.divide_by_zero, o_out_word.divide_by_zero);
                    end
                end
            end
        end
    end

    // Receiver: random stalls by mode, plus a long hold-off on request
    // counted here so that the block fills up and drops its ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                MODE_SEND_LAZY: i_out_ready <= ($urandom_range(0, 99) >= 87);
                MODE_RECV_LAZY: i_out_ready <= ($urandom_range(0, 99) >= 31);
                default:        i_out_ready <= 1'b1;
            endcase
        end
    end

    // Global watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("integer_alu_with_compare test failed");
            $finish;
        end
    end

    // Offer one word and hold it steady until the block takes it. The
    // sender may idle first, depending on the mode; valid stays high from
    // one word to the next when there is no idle cycle between them.
    task automatic send_word(input ialu_pkg::t_in_word w);
        int unsigned idle_pct;
        idle_pct = (idle_mode == MODE_SEND_LAZY) ? 31 :
                   (idle_mode == MODE_RECV_LAZY) ? 87 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int unsigned count);
        ialu_pkg::t_in_word w;
        for (int unsigned n = 0; n < count; n++) begin
            w = make_word(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_operand(), pick_operand());
            send_word(w);
        end
    endtask

    initial begin
        ialu_pkg::t_out_word predicted;
        // Directed rows: extremes, every command, and the corner cases.
        add_row(make_word(ialu_pkg::CMD_ADD, 0, 0, 32'hFFFF_FFFF, 32'd1), 1,
                mk_out(0, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_SUB, 0, 0, 32'd0, 32'd1), 1, mk_out('1, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_MUL, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                mk_out(1, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_MUL, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                mk_out(1, 32'hFFFF_FFFE, 1, 0));
        add_row(make_word(ialu_pkg::CMD_MUL, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                mk_out(1, 0, 1, 0));
        add_row(make_word(ialu_pkg::CMD_MUL, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF), 0, '0);
        add_row(make_word(ialu_pkg::CMD_DIV, 0, 0, 32'd7, 32'd0), 1, mk_out('1, 0, 0, 1));
        add_row(make_word(ialu_pkg::CMD_DIV, 1, 1, 32'd9, 32'd0), 1, mk_out('1, 9, 1, 1));
        add_row(make_word(ialu_pkg::CMD_REM, 0, 0, 32'h8000_0000, 32'd0), 1,
                mk_out(32'h8000_0000, 0, 0, 1));
        add_row(make_word(ialu_pkg::CMD_DIV, 0, 1, 32'h8000_0000, 32'hFFFF_FFFF), 1,
                mk_out(32'h8000_0000, 0, 1, 0));
        add_row(make_word(ialu_pkg::CMD_DIV, 0, 1, -32'sd7, 32'd2), 1,
                mk_out(-32'sd3, -32'sd1, 1, 0));
        add_row(make_word(ialu_pkg::CMD_REM, 1, 0, 32'hFFFF_FFFF, 32'd10), 1,
                mk_out(5, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_XOR, 0, 1, 32'hFFFF_FFFF, 32'h0F0F_0F0F), 1,
                mk_out(32'hF0F0_F0F0, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_NEG, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF), 1,
                mk_out(32'h8000_0000, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_NEG, 1, 0, 32'h0000_00FF, 32'd0), 1,
                mk_out(32'hFFFF_FF00, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_GT, 1, 0, 32'd1, 32'hFFFF_FFFF), 1,
                mk_out(1, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_GE, 0, 0, 32'h8000_0000, 32'h8000_0000), 1,
                mk_out(1, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_LT, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF), 1,
                mk_out(1, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_LE, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000), 1,
                mk_out(0, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_EQ, 0, 0, 32'h1234_5678, 32'h1234_5678), 1,
                mk_out(1, 0, 0, 0));
        add_row(make_word(ialu_pkg::CMD_NE, 0, 0, 32'h1234_5678, 32'h1234_5678), 1,
                mk_out(0, 0, 0, 0));
        add_row(make_word(4'd13, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, '0);
        add_row(make_word(4'd15, 0, 0, 32'd5, 32'd6), 1, '0);
        add_row(make_word(ialu_pkg::CMD_ADD, 1, 1, 32'd0, 32'd0), 1, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, walked in order; hand-typed results cross-check
        // the predictor before it is trusted for the random words.
        foreach (directed_rows[k]) begin
            if (directed_rows[k].has_golden) begin
                predicted = compute_alu_result(directed_rows[k].stim);
                if (predicted !== directed_rows[k].golden) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("table row %0d: expected %h, predictor %h", k,
                                 directed_rows[k].golden, predicted);
                    end
                end
            end
            send_word(directed_rows[k].stim);
        end

        // Sender lazy, receiver mostly stalled.
        idle_mode = MODE_SEND_LAZY;
        send_random(RandomWords / 3);
        // Sender pauses until every result has come home.
        drain_results();

        // Receiver lazy; partway through it holds off for a long stretch
        // while the sender keeps offering words, filling the pipeline.
        idle_mode = MODE_RECV_LAZY;
        send_random(RandomWords / 6);
        hold_off = 120;
        idle_mode = MODE_NO_IDLE;
        send_random(60);
        idle_mode = MODE_RECV_LAZY;
        send_random(RandomWords / 6 - 60);

        // Neither side idles.
        idle_mode = MODE_NO_IDLE;
        send_random(RandomWords / 3);

        drain_results();
        repeat (Latency + 10) @(posedge i_clk);

        $display("Checked %0d result words over %0d words sent: all commands, corners,",
                 words_checked, words_sent);
        $display("zero divisors, overflow and three idling patterns with a long stall.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("integer_alu_with_compare test passed");
        end else begin
            $display("integer_alu_with_compare test failed");
        end
        $finish;
    end

endmodule
